/* sv/shdlc_response_deframer_defines.svh */
// assertion macros for the shdlc response deframer
// expects clk and rst to be visible in the module that uses them
`ifndef SHDLC_RESPONSE_DEFRAMER_DEFINES_SVH
`define SHDLC_RESPONSE_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHDLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shdlc deframer: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SHDLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shdlc deframer: next-cycle check failed");

`endif

/* sv/shdlc_pkg.sv */
// shared types and constants of the shdlc response deframer
// no dependencies; used by every module of the block
`default_nettype none

package shdlc_pkg;

  // frame limits
  localparam int MAX_FRAME = 64;
  localparam int COUNT_W   = 7;
  localparam int MIN_FRAME = 5;
  localparam int HDR_BYTES = 4;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);

  // header byte positions
  localparam int HDR_ADDRESS = 0;
  localparam int HDR_COMMAND = 1;
  localparam int HDR_STATE   = 2;
  localparam int HDR_LENGTH  = 3;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // line codes
  localparam logic [7:0] DELIM    = 8'h7E;
  localparam logic [7:0] ESC      = 8'h7D;
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] STATE_OK = 8'h00;

  // configuration register indexes
  localparam logic CFG_IDX_ADDRESS = 1'b0;
  localparam logic CFG_IDX_COMMAND = 1'b1;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_CHECKSUM  = 3'd2,
    ERR_HEADER    = 3'd3,
    ERR_DEV_STATE = 3'd4,
    ERR_LENGTH    = 3'd5,
    ERR_OVERSIZE  = 3'd6
  } err_t;

  typedef enum logic {
    ST_HUNT  = 1'b0,
    ST_FRAME = 1'b1
  } rx_state_t;

  // classified received byte
  typedef struct packed {
    logic       is_delim;
    logic       is_esc;
    logic [7:0] data;
  } rx_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    rx_item_t item;
  } q_head_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    err_t       error_code;
    logic [7:0] device_state;
    logic [7:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

/* sv/shdlc_front.sv */
// front end: takes raw bytes and tags delimiter and escape codes
// depends on shdlc_pkg
`default_nettype none

module shdlc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          rx_byte,
  output logic                     f_valid,
  output shdlc_pkg::rx_item_t      f_item,
  input  wire logic                q_ready
);

  logic accept;
  logic push;

  assign push     = f_valid && q_ready;
  assign in_ready = !f_valid || q_ready;
  assign accept   = in_valid && in_ready;

  // valid flag of the front stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  // classify the request
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.is_delim <= (rx_byte == shdlc_pkg::DELIM);
      f_item.is_esc   <= (rx_byte == shdlc_pkg::ESC);
      f_item.data     <= rx_byte;
    end
  end

endmodule

`default_nettype wire

/* sv/shdlc_queue.sv */
// short queue between the front end and the back end
// depends on shdlc_pkg
`default_nettype none

module shdlc_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire shdlc_pkg::rx_item_t push_item,
  output logic                     q_ready,
  input  wire logic                pop,
  output shdlc_pkg::q_head_t       head
);

  shdlc_pkg::rx_item_t                entries [shdlc_pkg::Q_DEPTH];
  logic [shdlc_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [shdlc_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [shdlc_pkg::Q_CNT_W-1:0]      fill;
  logic                               do_push;
  logic                               do_pop;

  assign q_ready    = (fill != shdlc_pkg::Q_CNT_W'(shdlc_pkg::Q_DEPTH));
  assign do_push    = push && q_ready;
  assign do_pop     = pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.item  = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == shdlc_pkg::Q_PTR_W'(shdlc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == shdlc_pkg::Q_PTR_W'(shdlc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* sv/shdlc_back.sv */
// back end: frame tracking, destuffing, checks and the output register
// depends on shdlc_pkg and shdlc_response_deframer_defines.svh
`default_nettype none
`include "shdlc_response_deframer_defines.svh"

module shdlc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  wire shdlc_pkg::q_head_t  head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output shdlc_pkg::result_t       res
);

  localparam int CW = shdlc_pkg::COUNT_W;

  logic [7:0]                 device_address;
  logic [7:0]                 expected_command;

  shdlc_pkg::rx_state_t       state, state_next;
  logic                       esc_pend, esc_pend_next;
  logic [CW-1:0]              cnt, cnt_next;
  logic [7:0]                 sum, sum_next;
  logic [7:0]                 prev, prev_next;
  logic [7:0]                 hdr [shdlc_pkg::HDR_BYTES];
  logic [7:0]                 hdr_next [shdlc_pkg::HDR_BYTES];

  logic                       take;
  logic                       emit;
  shdlc_pkg::result_t         res_new;
  shdlc_pkg::err_t            frame_err;
  logic [7:0]                 v;
  logic [7:0]                 body_sum;
  logic                       close_frame;
  logic                       esc_marker;
  logic                       oversize;

  assign take        = head.valid && (!out_valid || out_ready);
  assign pop         = take;
  assign close_frame = (state == shdlc_pkg::ST_FRAME) && (cnt != '0);
  assign esc_marker  = !esc_pend && head.item.is_esc;
  assign oversize    = (cnt >= CW'(shdlc_pkg::MAX_FRAME));
  assign v           = esc_pend ? (head.item.data ^ shdlc_pkg::ESC_XOR) : head.item.data;
  assign body_sum    = sum - prev;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= 8'h00;
      expected_command <= 8'h00;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        shdlc_pkg::CFG_IDX_ADDRESS: device_address   <= cfg_data;
        shdlc_pkg::CFG_IDX_COMMAND: expected_command <= cfg_data;
        default:                    device_address   <= device_address;
      endcase
    end
  end

  // end-of-frame checks, first failing one wins
  always_comb begin
    priority if (cnt < CW'(shdlc_pkg::MIN_FRAME)) begin
      frame_err = shdlc_pkg::ERR_SHORT;
    end else if (~body_sum != prev) begin
      frame_err = shdlc_pkg::ERR_CHECKSUM;
    end else if (hdr[shdlc_pkg::HDR_ADDRESS] != device_address ||
                 hdr[shdlc_pkg::HDR_COMMAND] != expected_command) begin
      frame_err = shdlc_pkg::ERR_HEADER;
    end else if (hdr[shdlc_pkg::HDR_STATE] != shdlc_pkg::STATE_OK) begin
      frame_err = shdlc_pkg::ERR_DEV_STATE;
    end else if (9'(cnt) != 9'(hdr[shdlc_pkg::HDR_LENGTH]) + 9'(shdlc_pkg::MIN_FRAME)) begin
      frame_err = shdlc_pkg::ERR_LENGTH;
    end else begin
      frame_err = shdlc_pkg::ERR_OK;
    end
  end

  // hunting / in-frame next state
  always_comb begin
    state_next = state;
    if (take) begin
      priority if (head.item.is_delim) begin
        state_next = close_frame ? shdlc_pkg::ST_HUNT : shdlc_pkg::ST_FRAME;
      end else if (state == shdlc_pkg::ST_FRAME && !esc_marker && oversize) begin
        state_next = shdlc_pkg::ST_HUNT;
      end else begin
        state_next = state;
      end
    end
  end

  // frame datapath and result selection
  always_comb begin
    esc_pend_next = esc_pend;
    cnt_next      = cnt;
    sum_next      = sum;
    prev_next     = prev;
    for (int i = 0; i < shdlc_pkg::HDR_BYTES; i++) begin
      hdr_next[i] = hdr[i];
    end
    emit    = 1'b0;
    res_new = '0;
    if (take) begin
      if (head.item.is_delim) begin
        esc_pend_next = 1'b0;
        if (close_frame) begin
          emit                   = 1'b1;
          res_new.is_status      = 1'b1;
          res_new.error_code     = frame_err;
          res_new.device_state   = hdr[shdlc_pkg::HDR_STATE];
          res_new.payload_length = hdr[shdlc_pkg::HDR_LENGTH];
        end else begin
          cnt_next  = '0;
          sum_next  = 8'h00;
          prev_next = 8'h00;
          for (int i = 0; i < shdlc_pkg::HDR_BYTES; i++) begin
            hdr_next[i] = 8'h00;
          end
        end
      end else if (state == shdlc_pkg::ST_FRAME) begin
        if (esc_marker) begin
          esc_pend_next = 1'b1;
        end else begin
          esc_pend_next = 1'b0;
          if (oversize) begin
            emit                   = 1'b1;
            res_new.is_status      = 1'b1;
            res_new.error_code     = shdlc_pkg::ERR_OVERSIZE;
            res_new.device_state   = hdr[shdlc_pkg::HDR_STATE];
            res_new.payload_length = hdr[shdlc_pkg::HDR_LENGTH];
          end else begin
            if (cnt < CW'(shdlc_pkg::HDR_BYTES)) begin
              hdr_next[cnt[shdlc_pkg::HDR_IDX_W-1:0]] = v;
            end
            // payload goes out one byte late so the checksum byte never does
            if (cnt >= CW'(shdlc_pkg::MIN_FRAME)) begin
              emit                 = 1'b1;
              res_new.payload_byte = prev;
            end
            sum_next  = sum + v;
            prev_next = v;
            cnt_next  = cnt + 1'b1;
          end
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= shdlc_pkg::ST_HUNT;
      esc_pend <= 1'b0;
      cnt      <= '0;
      sum      <= 8'h00;
      prev     <= 8'h00;
      for (int i = 0; i < shdlc_pkg::HDR_BYTES; i++) begin
        hdr[i] <= 8'h00;
      end
    end else begin
      state    <= state_next;
      esc_pend <= esc_pend_next;
      cnt      <= cnt_next;
      sum      <= sum_next;
      prev     <= prev_next;
      for (int i = 0; i < shdlc_pkg::HDR_BYTES; i++) begin
        hdr[i] <= hdr_next[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_new;
    end
  end

  // checks
  `SHDLC_ASSERT_IMPL(a_esc_only_in_frame, esc_pend, state == shdlc_pkg::ST_FRAME)
  `SHDLC_ASSERT_IMPL(a_count_bound, 1'b1, cnt <= CW'(shdlc_pkg::MAX_FRAME))
  `SHDLC_ASSERT_IMPL(a_payload_clean, out_valid && !res.is_status,
                     res.error_code == shdlc_pkg::ERR_OK && res.device_state == 8'h00 &&
                     res.payload_length == 8'h00)
  `SHDLC_ASSERT_NEXT(a_payload_after_header, take && emit && !res_new.is_status,
                     cnt > CW'(shdlc_pkg::MIN_FRAME))

endmodule

`default_nettype wire

/* sv/shdlc_response_deframer.sv */
// shdlc response deframer, top level
// channels: in (rx_byte) takes one raw serial byte per request; out gives at
// most one result per request (a payload byte or an end-of-frame status); cfg
// writes device_address (index 0) and expected_command (index 1), always ready.
// bytes are hunted for a 0x7E delimiter, 0x7D escapes are removed, and the
// four header bytes, running sum and previous byte are kept per frame.
// throughput: one byte per cycle sustained while out_ready stays high; the
// back end retires one queued byte per cycle whenever its output register
// is empty or being taken. a byte accepted passes the front register, then
// the two-entry queue, then its result (if any) goes to the output register.
// a payload byte leaves one byte late, so the checksum byte never appears.
// reset (rst, synchronous) clears both registers, puts the receiver into
// hunting and empties the front stage, queue and output register.
// when the receiver stalls, the output register holds its result, the back end
// stops, the queue fills and in_ready drops after at most three bytes. the user
// must write configuration only while no frame byte is in flight; the block has no check.
`default_nettype none

module shdlc_response_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            is_status,
  output logic [7:0]      payload_byte,
  output logic [2:0]      error_code,
  output logic [7:0]      device_state,
  output logic [7:0]      payload_length,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic                   f_valid;
  shdlc_pkg::rx_item_t    f_item;
  logic                   q_ready;
  logic                   pop;
  shdlc_pkg::q_head_t     head;
  shdlc_pkg::result_t     res;

  assign cfg_ready = 1'b1;

  // byte intake and classification
  shdlc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .f_valid  (f_valid),
    .f_item   (f_item),
    .q_ready  (q_ready)
  );

  // decoupling queue
  shdlc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .head      (head)
  );

  // frame processing and results
  shdlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // result fields
  assign is_status      = res.is_status;
  assign payload_byte   = res.payload_byte;
  assign error_code     = res.error_code;
  assign device_state   = res.device_state;
  assign payload_length = res.payload_length;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the shdlc response deframer
// drives raw serial bytes and register writes, predicts every result in-line
// depends on shdlc_pkg and the shdlc_response_deframer top level
`timescale 1ns / 1ps

module testbench;

  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 50;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int TIMEOUT_NS   = 400000;

  typedef enum int {
    FK_GOOD,
    FK_BAD_SUM,
    FK_BAD_ADDR,
    FK_BAD_CMD,
    FK_BAD_STATE,
    FK_BAD_LEN,
    FK_SHORT,
    FK_NOISE,
    FK_OVERSIZE
  } frame_kind_t;

  typedef struct {
    logic [7:0]      data;
    logic            pin;
    shdlc_pkg::err_t pin_err;
  } row_t;

  // block inputs, known from time zero
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_index = shdlc_pkg::CFG_IDX_ADDRESS;
  logic [7:0] cfg_data  = 8'h00;

  // block outputs
  logic       in_ready;
  logic       out_valid;
  logic       is_status;
  logic [7:0] payload_byte;
  logic [2:0] error_code;
  logic [7:0] device_state;
  logic [7:0] payload_length;
  logic       cfg_ready;

  // deframer prediction state
  logic                          fr_open = 1'b0;
  logic                          fr_esc  = 1'b0;
  logic [shdlc_pkg::COUNT_W-1:0] fr_count = '0;
  logic [7:0]                    fr_sum  = 8'h00;
  logic [7:0]                    fr_prev = 8'h00;
  logic [7:0]                    fr_hdr [shdlc_pkg::HDR_BYTES] = '{default: 8'h00};
  logic [7:0]                    addr_reg = 8'h00;
  logic [7:0]                    cmd_reg  = 8'h00;
  shdlc_pkg::result_t            due_results [$];

  // run bookkeeping
  logic             row_pin      = 1'b0;
  shdlc_pkg::err_t  row_code     = shdlc_pkg::ERR_OK;
  logic             quiet        = 1'b0;
  logic             hold_pending = 1'b0;
  int               errors          = 0;
  int               bytes_accepted  = 0;
  int               results_checked = 0;
  int               settings_run    = 0;
  int               status_seen [0:6] = '{default: 0};
  row_t             directed_rows [23];

  shdlc_response_deframer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_status      (is_status),
    .payload_byte   (payload_byte),
    .error_code     (error_code),
    .device_state   (device_state),
    .payload_length (payload_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // end-of-frame checks, first failing one wins
  function automatic shdlc_pkg::err_t close_status();
    logic [7:0] body_sum;
    logic [7:0] inv_sum;
    if (fr_count < shdlc_pkg::MIN_FRAME) return shdlc_pkg::ERR_SHORT;
    body_sum = fr_sum - fr_prev;
    inv_sum  = ~body_sum;
    if (inv_sum != fr_prev) return shdlc_pkg::ERR_CHECKSUM;
    if (fr_hdr[shdlc_pkg::HDR_ADDRESS] != addr_reg ||
        fr_hdr[shdlc_pkg::HDR_COMMAND] != cmd_reg) return shdlc_pkg::ERR_HEADER;
    if (fr_hdr[shdlc_pkg::HDR_STATE] != shdlc_pkg::STATE_OK) return shdlc_pkg::ERR_DEV_STATE;
    if (int'(fr_count) != int'(fr_hdr[shdlc_pkg::HDR_LENGTH]) + shdlc_pkg::MIN_FRAME)
      return shdlc_pkg::ERR_LENGTH;
    return shdlc_pkg::ERR_OK;
  endfunction

  // advance the deframer by one raw byte, queue what it gives
  task automatic deframe_byte(input logic [7:0] raw, input logic pin,
                              input shdlc_pkg::err_t pin_err);
    logic [7:0]         v;
    shdlc_pkg::result_t r;
    v = raw;
    r = '0;
    if (v == shdlc_pkg::DELIM) begin
      if (fr_open && fr_count != '0) begin
        r.is_status      = 1'b1;
        r.error_code     = pin ? pin_err : close_status();
        r.device_state   = fr_hdr[shdlc_pkg::HDR_STATE];
        r.payload_length = fr_hdr[shdlc_pkg::HDR_LENGTH];
        due_results.push_back(r);
        fr_open = 1'b0;
        fr_esc  = 1'b0;
      end else begin
        // opening or restarting delimiter
        fr_open  = 1'b1;
        fr_esc   = 1'b0;
        fr_count = '0;
        fr_sum   = 8'h00;
        fr_prev  = 8'h00;
        foreach (fr_hdr[i]) fr_hdr[i] = 8'h00;
      end
    end else if (fr_open && (fr_esc || v != shdlc_pkg::ESC)) begin
      if (fr_esc) v = v ^ shdlc_pkg::ESC_XOR;
      fr_esc = 1'b0;
      if (fr_count >= shdlc_pkg::MAX_FRAME) begin
        r.is_status      = 1'b1;
        r.error_code     = shdlc_pkg::ERR_OVERSIZE;
        r.device_state   = fr_hdr[shdlc_pkg::HDR_STATE];
        r.payload_length = fr_hdr[shdlc_pkg::HDR_LENGTH];
        due_results.push_back(r);
        fr_open = 1'b0;
      end else begin
        if (fr_count < shdlc_pkg::HDR_BYTES) fr_hdr[fr_count[shdlc_pkg::HDR_IDX_W-1:0]] = v;
        // payload leaves one byte late
        if (fr_count >= shdlc_pkg::MIN_FRAME) begin
          r.payload_byte = fr_prev;
          due_results.push_back(r);
        end
        fr_sum   = fr_sum + v;
        fr_prev  = v;
        fr_count = fr_count + 1'b1;
      end
    end else if (fr_open) begin
      fr_esc = 1'b1;
    end
  endtask

  task automatic compare_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      errors++;
    end
  endtask

  // output check first, then prediction of the byte taken at this edge
  always @(posedge clk) begin
    shdlc_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing due, expected none, %s %0b byte %0h code %0d",
                 $time, "actual status", is_status, payload_byte, error_code);
        errors++;
      end else begin
        want = due_results.pop_front();
        compare_field("is_status", want.is_status, is_status);
        compare_field("payload_byte", want.payload_byte, payload_byte);
        compare_field("error_code", want.error_code, error_code);
        compare_field("device_state", want.device_state, device_state);
        compare_field("payload_length", want.payload_length, payload_length);
        results_checked++;
        if (is_status && error_code <= shdlc_pkg::ERR_OVERSIZE) status_seen[error_code]++;
      end
    end
    if (!rst && in_valid && in_ready) begin
      deframe_byte(rx_byte, row_pin, row_code);
      bytes_accepted++;
    end
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_pending) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // offer one byte, hold it until the request is taken
  task automatic send_byte(input logic [7:0] b, input logic pin = 1'b0,
                           input shdlc_pkg::err_t pin_err = shdlc_pkg::ERR_OK);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    row_pin  = pin;
    row_code = pin_err;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == shdlc_pkg::CFG_IDX_ADDRESS) addr_reg = value;
    else cmd_reg = value;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] cmd);
    write_reg(shdlc_pkg::CFG_IDX_ADDRESS, addr);
    write_reg(shdlc_pkg::CFG_IDX_COMMAND, cmd);
    cfg_valid = 1'b0;
    settings_run++;
  endtask

  // stop offering and let the pipeline run dry
  task automatic settle();
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // data bytes biased toward the line codes
  function automatic logic [7:0] payload_pick();
    case ($urandom_range(0, 7))
      0:       return shdlc_pkg::DELIM;
      1:       return shdlc_pkg::ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return FK_GOOD;
    if (r < 57) return FK_BAD_SUM;
    if (r < 63) return FK_BAD_ADDR;
    if (r < 69) return FK_BAD_CMD;
    if (r < 75) return FK_BAD_STATE;
    if (r < 82) return FK_BAD_LEN;
    if (r < 90) return FK_SHORT;
    if (r < 98) return FK_NOISE;
    return FK_OVERSIZE;
  endfunction

  // build one frame of the given kind and send it byte-stuffed
  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] body [$];
    logic [7:0] total;
    int         len;
    body  = {};
    total = 8'h00;
    case (kind)
      FK_NOISE: begin
        repeat ($urandom_range(1, 6)) send_byte(payload_pick());
        return;
      end
      FK_SHORT:
        repeat ($urandom_range(0, shdlc_pkg::MIN_FRAME - 1)) body.push_back(payload_pick());
      FK_OVERSIZE:
        repeat ($urandom_range(shdlc_pkg::MAX_FRAME + 1, shdlc_pkg::MAX_FRAME + 6))
          body.push_back(8'($urandom));
      default: begin
        len = ($urandom_range(0, 9) == 0)
              ? $urandom_range(7, shdlc_pkg::MAX_FRAME - shdlc_pkg::MIN_FRAME)
              : $urandom_range(0, 6);
        body.push_back(kind == FK_BAD_ADDR ? addr_reg ^ 8'($urandom_range(1, 255)) : addr_reg);
        body.push_back(kind == FK_BAD_CMD ? cmd_reg ^ 8'($urandom_range(1, 255)) : cmd_reg);
        body.push_back(kind == FK_BAD_STATE ? 8'($urandom_range(1, 255)) : shdlc_pkg::STATE_OK);
        body.push_back(8'(len) ^ (kind == FK_BAD_LEN ? 8'($urandom_range(1, 255)) : 8'h00));
        repeat (len) body.push_back(payload_pick());
        foreach (body[i]) total = total + body[i];
        body.push_back(8'(~total) ^ (kind == FK_BAD_SUM ? 8'($urandom_range(1, 255)) : 8'h00));
      end
    endcase
    send_byte(shdlc_pkg::DELIM);
    // line codes always escaped, now and then an ordinary byte as well
    foreach (body[i]) begin
      if (body[i] == shdlc_pkg::DELIM || body[i] == shdlc_pkg::ESC ||
          ($urandom_range(0, 19) == 0 && (body[i] ^ shdlc_pkg::ESC_XOR) != shdlc_pkg::DELIM))
      begin
        send_byte(shdlc_pkg::ESC);
        send_byte(body[i] ^ shdlc_pkg::ESC_XOR);
      end else begin
        send_byte(body[i]);
      end
    end
    // dangling escape ahead of the closing delimiter
    if ($urandom_range(0, 15) == 0) send_byte(shdlc_pkg::ESC);
    send_byte(shdlc_pkg::DELIM);
  endtask

  // main sequence
  initial begin
    int start;
    // bytes while hunting, empty-frame restart, short frame, good frame
    // closed after an escape, checksum error
    directed_rows = '{
      '{8'h00, 1'b0, shdlc_pkg::ERR_OK}, '{8'hFF, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h7E, 1'b0, shdlc_pkg::ERR_OK}, '{8'h7E, 1'b0, shdlc_pkg::ERR_OK},
      '{8'hAB, 1'b0, shdlc_pkg::ERR_OK}, '{8'h7E, 1'b1, shdlc_pkg::ERR_SHORT},
      '{8'h7E, 1'b0, shdlc_pkg::ERR_OK}, '{8'h00, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h00, 1'b0, shdlc_pkg::ERR_OK}, '{8'h00, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h01, 1'b0, shdlc_pkg::ERR_OK}, '{8'h7D, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h5D, 1'b0, shdlc_pkg::ERR_OK}, '{8'h81, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h7D, 1'b0, shdlc_pkg::ERR_OK}, '{8'h7E, 1'b1, shdlc_pkg::ERR_OK},
      '{8'h7E, 1'b0, shdlc_pkg::ERR_OK}, '{8'h00, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h00, 1'b0, shdlc_pkg::ERR_OK}, '{8'h00, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h00, 1'b0, shdlc_pkg::ERR_OK}, '{8'h55, 1'b0, shdlc_pkg::ERR_OK},
      '{8'h7E, 1'b1, shdlc_pkg::ERR_CHECKSUM}
    };
    rst = 1'b1;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    set_config(8'h00, 8'h00);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].pin, directed_rows[i].pin_err);
    settle();

    // random frames under several register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_config(8'hFF, 8'hFF);
        2:       set_config(8'h00, 8'hFF);
        default: set_config(8'($urandom), 8'($urandom));
      endcase
      quiet = (phase == PHASES - 1);
      if (phase == 0) hold_pending = 1'b1;
      if (phase == 1) send_frame(FK_OVERSIZE);
      start = bytes_accepted;
      while (bytes_accepted - start < PHASE_ITEMS) send_frame(pick_kind());
      settle();
    end

    $display("run covered %0d bytes, %0d results checked, %0d register settings",
             bytes_accepted, results_checked, settings_run);
    $display("status ok %0d short %0d sum %0d header %0d state %0d length %0d oversize %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("** shdlc_response_deframer: PASSED **");
    end else begin
      $display("** shdlc_response_deframer: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results still due", $time, due_results.size());
    $display("** shdlc_response_deframer: FAILED **");
    $finish;
  end

endmodule
